FILE: rtl/afu_pkg.sv
// afu_pkg: shared types, codes and elaboration-time table functions
// of the activation function unit
// no dependencies
`default_nettype none

package afu_pkg;

    localparam logic [1:0] MODE_SIGMOID = 2'd0;
    localparam logic [1:0] MODE_TANH    = 2'd1;
    localparam logic [1:0] MODE_RELU    = 2'd2;
    localparam logic [1:0] MODE_LINEAR  = 2'd3;

    localparam logic [1:0] CMD_APPLY = 2'd0;
    localparam logic [1:0] CMD_DX    = 2'd1;
    localparam logic [1:0] CMD_DY    = 2'd2;

    localparam logic [1:0] KIND_DIRECT     = 2'd0;
    localparam logic [1:0] KIND_FUNC       = 2'd1;
    localparam logic [1:0] KIND_FUNC_DERIV = 2'd2;
    localparam logic [1:0] KIND_DERIV      = 2'd3;

    localparam logic signed [15:0] Q_ONE  = 16'sd2048;
    localparam logic signed [15:0] Q_ZERO = 16'sd0;

    typedef struct packed {
        logic [1:0]         kind;
        logic               tanh;
        logic signed [15:0] value;
        logic signed [15:0] direct;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    // exp(-d) in q30 from a truncated taylor series
    function automatic logic [63:0] exp_step(input logic [63:0] d);
        logic signed [63:0] sum;
        logic [63:0]        term;
        int                 k;
        sum  = 64'sd1 <<< 30;
        term = 64'd1 << 30;
        for (k = 1; k <= 24; k++)
        begin
            term = ((term * d) >> 30) / 64'(k);
            if (k % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        return 64'(sum);
    endfunction

    // table entry i as exp(-d)^i in q30
    function automatic logic [30:0] exp_entry(input logic [63:0] step, input int i);
        logic [63:0] acc;
        logic [63:0] hi;
        logic [63:0] lo;
        int          k;
        acc = 64'd1 << 60;
        for (k = 1; k <= i; k++)
        begin
            hi  = acc >> 30;
            lo  = acc & ((64'd1 << 30) - 64'd1);
            acc = hi * step + ((lo * step) >> 30);
        end
        acc = (acc + (64'd1 << 29)) >> 30;
        return acc[30:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
        if (v > 26'sd32767)
            return 16'sh7fff;
        else if (v < -26'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/afu_if.sv
// afu channel interfaces: operand input, result output and mode write
// no dependencies
`default_nettype none

interface afu_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [15:0] value;
    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

interface afu_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] result;
    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

interface afu_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    modport source (output valid, output mode, input ready);
    modport sink (input valid, input mode, output ready);
endinterface

`default_nettype wire

FILE: rtl/afu_front.sv
// afu_front: accepts operand transactions and classifies them by mode and command
// depends on afu_pkg and afu_if
`default_nettype none

module afu_front (
    afu_in_if.sink         src,
    input  logic [1:0]     mode,
    input  afu_pkg::qstat_t qs,
    output logic           push,
    output afu_pkg::item_t push_item
);

    logic signed [15:0] v;
    logic               pos;

    assign v         = src.value;
    assign pos       = (v > afu_pkg::Q_ZERO);
    assign src.ready = !qs.full;
    assign push      = src.valid && src.ready;

    always_comb
    begin
        push_item.kind   = afu_pkg::KIND_DIRECT;
        push_item.tanh   = (mode == afu_pkg::MODE_TANH);
        push_item.value  = v;
        push_item.direct = afu_pkg::Q_ZERO;
        case (mode)
            afu_pkg::MODE_SIGMOID, afu_pkg::MODE_TANH:
            begin
                case (src.cmd)
                    afu_pkg::CMD_APPLY: push_item.kind = afu_pkg::KIND_FUNC;
                    afu_pkg::CMD_DX:    push_item.kind = afu_pkg::KIND_FUNC_DERIV;
                    afu_pkg::CMD_DY:    push_item.kind = afu_pkg::KIND_DERIV;
                    default:            push_item.kind = afu_pkg::KIND_DIRECT;
                endcase
            end
            afu_pkg::MODE_RELU:
            begin
                case (src.cmd)
                    afu_pkg::CMD_APPLY:
                        push_item.direct = pos ? v : afu_pkg::Q_ZERO;
                    afu_pkg::CMD_DX, afu_pkg::CMD_DY:
                        push_item.direct = pos ? afu_pkg::Q_ONE : afu_pkg::Q_ZERO;
                    default:
                        push_item.direct = afu_pkg::Q_ZERO;
                endcase
            end
            default:
            begin
                case (src.cmd)
                    afu_pkg::CMD_APPLY:               push_item.direct = v;
                    afu_pkg::CMD_DX, afu_pkg::CMD_DY: push_item.direct = afu_pkg::Q_ONE;
                    default:                          push_item.direct = afu_pkg::Q_ZERO;
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/afu_queue.sv
// afu_queue: two-entry queue of classified items between front and back
// depends on afu_pkg
`default_nettype none

module afu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  afu_pkg::item_t  push_item,
    input  logic            pop,
    output logic            head_valid,
    output afu_pkg::item_t  head,
    output afu_pkg::qstat_t qs
);

    afu_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != 2'd0);
    assign qs.empty   = (cnt_reg == 2'd0);
    assign qs.full    = (cnt_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

FILE: rtl/afu_back.sv
// afu_back: exp table interpolation, pipelined divider, derivative and saturation
// depends on afu_pkg and afu_if
`default_nettype none

module afu_back #(
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  afu_pkg::item_t head,
    output logic           pop,
    afu_out_if.source      dst
);

    localparam int NW   = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int PW   = 16 + NW;
    localparam int DIVS = 6;
    localparam logic [63:0] STEP_D = (64'd1 << 34) / EXP_TABLE_ENTRIES;
    localparam logic [63:0] STEP   = afu_pkg::exp_step(STEP_D);

    logic [30:0] exp_tab [EXP_TABLE_ENTRIES + 1];

    for (genvar gi = 0; gi <= EXP_TABLE_ENTRIES; gi++)
    begin : g_tab
        assign exp_tab[gi] = afu_pkg::exp_entry(STEP, gi);
    end

    logic en;

    // stage a: exp argument and table position
    logic [15:0]    abs_v;
    logic [16:0]    dbl_v;
    logic [15:0]    arg;
    logic           a_vld_reg;
    afu_pkg::item_t a_it_reg;
    logic [PW-1:0]  a_pos_reg;

    // stage b: table read
    logic [NW-1:0]  idx;
    logic [30:0]    t0;
    logic [30:0]    t1;
    logic           b_vld_reg;
    afu_pkg::item_t b_it_reg;
    logic [30:0]    b_t0_reg;
    logic [30:0]    b_diff_reg;
    logic [14:0]    b_frac_reg;

    // stage c: interpolation product
    logic           c_vld_reg;
    afu_pkg::item_t c_it_reg;
    logic [30:0]    c_t0_reg;
    logic [45:0]    c_prod_reg;

    // stage d: divider operands
    logic [30:0]    e;
    logic [31:0]    den;
    logic [41:0]    num;
    logic           d_vld_reg;
    afu_pkg::item_t d_it_reg;
    logic [43:0]    d_rem_reg;
    logic [31:0]    d_den_reg;

    // divider stages, two quotient bits each
    logic           dvi_vld [DIVS];
    afu_pkg::item_t dvi_it  [DIVS];
    logic [43:0]    dvi_rem [DIVS];
    logic [11:0]    dvi_q   [DIVS];
    logic [31:0]    dvi_den [DIVS];
    logic [43:0]    dvo_rem [DIVS];
    logic [11:0]    dvo_q   [DIVS];
    logic           dv_vld_reg [DIVS];
    afu_pkg::item_t dv_it_reg  [DIVS];
    logic [43:0]    dv_rem_reg [DIVS];
    logic [11:0]    dv_q_reg   [DIVS];
    logic [31:0]    dv_den_reg [DIVS];

    // stage f: sign fix and derivative product
    afu_pkg::item_t     fin_it;
    logic [11:0]        fin_q;
    logic signed [16:0] qs17;
    logic signed [16:0] fs;
    logic signed [16:0] y;
    logic signed [17:0] m2;
    logic signed [34:0] p;
    logic               f_vld_reg;
    afu_pkg::item_t     f_it_reg;
    logic signed [15:0] f_fs_reg;
    logic signed [34:0] f_p_reg;

    // stage g: rounding, saturation and output register
    logic [34:0]        mag;
    logic [34:0]        rnd;
    logic signed [25:0] rq;
    logic signed [15:0] res_next;
    logic               out_vld_reg;
    logic signed [15:0] out_res_reg;

    assign en         = !out_vld_reg || dst.ready;
    assign pop        = head_valid && en;
    assign dst.valid  = out_vld_reg;
    assign dst.result = out_res_reg;

    always_comb
    begin
        abs_v = head.value[15] ? 16'(-head.value) : 16'(head.value);
        dbl_v = {abs_v, 1'b0};
        if (head.tanh)
            arg = (dbl_v > 17'd32768) ? 16'h8000 : dbl_v[15:0];
        else
            arg = abs_v;
    end

    assign idx = a_pos_reg[14+NW:15];
    assign t0  = exp_tab[idx];
    assign t1  = (idx == NW'(EXP_TABLE_ENTRIES)) ? t0 : exp_tab[NW'(idx + 1'b1)];

    always_comb
    begin
        e   = c_t0_reg - c_prod_reg[45:15];
        den = 32'h4000_0000 + {1'b0, e};
        if (c_it_reg.tanh)
            num = {31'h4000_0000 - e, 11'd0};
        else
            num = 42'h200_0000_0000;
    end

    for (genvar gs = 0; gs < DIVS; gs++)
    begin : g_div
        localparam int B0 = 11 - 2 * gs;
        logic [43:0] sh0;
        logic [43:0] sh1;
        logic [43:0] r0;

        if (gs == 0)
        begin : g_first
            assign dvi_vld[gs] = d_vld_reg;
            assign dvi_it[gs]  = d_it_reg;
            assign dvi_rem[gs] = d_rem_reg;
            assign dvi_q[gs]   = 12'd0;
            assign dvi_den[gs] = d_den_reg;
        end
        else
        begin : g_next
            assign dvi_vld[gs] = dv_vld_reg[gs-1];
            assign dvi_it[gs]  = dv_it_reg[gs-1];
            assign dvi_rem[gs] = dv_rem_reg[gs-1];
            assign dvi_q[gs]   = dv_q_reg[gs-1];
            assign dvi_den[gs] = dv_den_reg[gs-1];
        end

        always_comb
        begin
            sh0 = {12'd0, dvi_den[gs]} << B0;
            sh1 = {12'd0, dvi_den[gs]} << (B0 - 1);
            dvo_q[gs] = dvi_q[gs];
            if (dvi_rem[gs] >= sh0)
            begin
                r0 = dvi_rem[gs] - sh0;
                dvo_q[gs][B0] = 1'b1;
            end
            else
                r0 = dvi_rem[gs];
            if (r0 >= sh1)
            begin
                dvo_rem[gs] = r0 - sh1;
                dvo_q[gs][B0-1] = 1'b1;
            end
            else
                dvo_rem[gs] = r0;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[gs] <= 1'b0;
            else if (en)
                dv_vld_reg[gs] <= dvi_vld[gs];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_it_reg[gs]  <= dvi_it[gs];
                dv_rem_reg[gs] <= dvo_rem[gs];
                dv_q_reg[gs]   <= dvo_q[gs];
                dv_den_reg[gs] <= dvi_den[gs];
            end
        end
    end

    assign fin_it = dv_it_reg[DIVS-1];
    assign fin_q  = dv_q_reg[DIVS-1];

    always_comb
    begin
        qs17 = $signed({5'd0, fin_q});
        if (fin_it.tanh)
            fs = fin_it.value[15] ? -qs17 : qs17;
        else
            fs = fin_it.value[15] ? 17'sd2048 - qs17 : qs17;
        y  = (fin_it.kind == afu_pkg::KIND_DERIV) ? {fin_it.value[15], fin_it.value} : fs;
        m2 = fin_it.tanh ? {y[16], y} : 18'sd2048 - {y[16], y};
        p  = y * m2;
    end

    always_comb
    begin
        mag = f_p_reg[34] ? 35'(-f_p_reg) : 35'(f_p_reg);
        rnd = (mag + 35'd1024) >> 11;
        rq  = f_p_reg[34] ? -$signed({2'b00, rnd[23:0]}) : $signed({2'b00, rnd[23:0]});
        case (f_it_reg.kind)
            afu_pkg::KIND_DIRECT: res_next = f_it_reg.direct;
            afu_pkg::KIND_FUNC:   res_next = f_fs_reg;
            default:
                res_next = afu_pkg::sat16(f_it_reg.tanh ? 26'sd2048 - rq : rq);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg   <= head_valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            f_vld_reg   <= dv_vld_reg[DIVS-1];
            out_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_it_reg    <= head;
            a_pos_reg   <= PW'(arg) * PW'(EXP_TABLE_ENTRIES);
            b_it_reg    <= a_it_reg;
            b_t0_reg    <= t0;
            b_diff_reg  <= t0 - t1;
            b_frac_reg  <= a_pos_reg[14:0];
            c_it_reg    <= b_it_reg;
            c_t0_reg    <= b_t0_reg;
            c_prod_reg  <= 46'(b_diff_reg) * 46'(b_frac_reg);
            d_it_reg    <= c_it_reg;
            d_rem_reg   <= {2'b00, num + {11'd0, den[31:1]}};
            d_den_reg   <= den;
            f_it_reg    <= fin_it;
            f_fs_reg    <= fs[15:0];
            f_p_reg     <= p;
            out_res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/activation_function_unit_top.sv
// activation_function_unit_top: sigmoid, tanh, relu and linear with derivatives
// a result passes stages a to d, the divider, stage f and the output register
// throughput: one transaction per cycle while dst is ready, fully pipelined back end
// the divider resolves two quotient bits per stage over six stages
// reset clears the mode register to sigmoid and empties the queue and pipeline
// depends on afu_pkg, afu_if, afu_front, afu_queue and afu_back
`default_nettype none

module activation_function_unit_top #(
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    afu_cfg_if.sink   cfg,
    afu_in_if.sink    src,
    afu_out_if.source dst
);

    logic [1:0]      mode_reg, mode_next;
    afu_pkg::qstat_t qs;
    afu_pkg::item_t  push_item;
    afu_pkg::item_t  head;
    logic            push;
    logic            pop;
    logic            head_valid;

    assign cfg.ready = 1'b1;
    assign mode_next = (cfg.valid && cfg.ready) ? cfg.mode : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= afu_pkg::MODE_SIGMOID;
        else
            mode_reg <= mode_next;
    end

    afu_front u_front (
        .src       (src),
        .mode      (mode_reg),
        .qs        (qs),
        .push      (push),
        .push_item (push_item)
    );

    afu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .qs         (qs)
    );

    afu_back #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .dst        (dst)
    );

    a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg.valid && cfg.ready) |=> $stable(mode_reg))
        else $error("mode changed without a config transaction");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        qs.full |-> !src.ready)
        else $error("input ready while queue full");

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(qs.full && qs.empty))
        else $error("queue both full and empty");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        qs.empty |-> !pop)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// tb_top: self-checking bench for activation_function_unit_top, a directed table
// then random phases per mode, checked on table results or an in-bench predictor
// depends on afu_pkg, afu_if and activation_function_unit_top
`default_nettype none

module tb_top;

    localparam int N_EXP = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic [1:0]         mode;
        logic [1:0]         cmd;
        logic signed [15:0] value;
        bit                 typed;
        logic signed [15:0] result;
    } vector_t;

    typedef struct {
        bit                 typed;
        logic signed [15:0] result;
    } pending_t;

    logic clk;
    logic rst_n;

    afu_cfg_if cfg_bus();
    afu_in_if  in_bus();
    afu_out_if out_bus();

    activation_function_unit_top #(.EXP_TABLE_ENTRIES(N_EXP)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .src   (in_bus),
        .dst   (out_bus)
    );

    bit [63:0]          exp_lut[0:N_EXP];
    logic [1:0]         mode_shadow;
    logic signed [15:0] result_q[$];
    bit                 next_typed;
    logic signed [15:0] next_result;
    int                 error_count;
    int                 cycle_count;
    int                 burst_left;
    bit                 hold_req;
    int                 hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // exp(-16 i / N) in q30, stepped by a taylor-series exp(-d)
    function automatic void fill_exp_lut();
        bit [63:0]   d;
        longint      sum;
        bit [63:0]   term;
        bit [63:0]   acc;
        bit [63:0]   step;
        int          k;
        d    = (64'd16 << 30) / N_EXP;
        sum  = longint'(1) << 30;
        term = 64'd1 << 30;
        acc  = 64'd1 << 60;
        for (k = 1; k <= 24; k++)
        begin
            term = ((term * d) >> 30) / k;
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        step = sum;
        exp_lut[0] = 64'd1 << 30;
        for (k = 1; k <= N_EXP; k++)
        begin
            acc = (acc >> 30) * step + (((acc & ((64'd1 << 30) - 1)) * step) >> 30);
            exp_lut[k] = (acc + (64'd1 << 29)) >> 30;
        end
    endfunction

    function automatic bit [63:0] neg_exp(bit [63:0] u);
        bit [63:0] pos;
        bit [63:0] idx;
        bit [63:0] frac;
        if (u > 32768)
            u = 32768;
        pos  = u * N_EXP;
        idx  = pos >> 15;
        frac = pos & 64'h7fff;
        if (idx >= N_EXP)
            return exp_lut[N_EXP];
        return exp_lut[idx] - (((exp_lut[idx] - exp_lut[idx + 1]) * frac) >> 15);
    endfunction

    function automatic longint sigmoid_fx(longint x);
        bit [63:0] den;
        longint    s;
        den = (64'd1 << 30) + neg_exp(x < 0 ? -x : x);
        s   = longint'(((64'd1 << 41) + den / 2) / den);
        return x < 0 ? 2048 - s : s;
    endfunction

    function automatic longint tanh_fx(longint x);
        bit [63:0] e;
        bit [63:0] den;
        longint    t;
        e   = neg_exp(2 * (x < 0 ? -x : x));
        den = (64'd1 << 30) + e;
        t   = longint'((64'd2048 * ((64'd1 << 30) - e) + den / 2) / den);
        return x < 0 ? -t : t;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint round_q11(longint p);
        if (p >= 0)
            return (p + 1024) >>> 11;
        return -(((-p) + 1024) >>> 11);
    endfunction

    function automatic longint slope_of_output(logic [1:0] m, longint y);
        case (m)
            afu_pkg::MODE_SIGMOID: return clamp16(round_q11(y * (2048 - y)));
            afu_pkg::MODE_TANH:    return clamp16(2048 - round_q11(y * y));
            afu_pkg::MODE_RELU:    return y > 0 ? 2048 : 0;
            default:               return 2048;
        endcase
    endfunction

    function automatic logic signed [15:0] activation(logic [1:0] m, logic [1:0] c,
                                                      logic signed [15:0] v);
        longint x;
        longint r;
        x = v;
        r = 0;
        if (c == afu_pkg::CMD_APPLY)
        begin
            case (m)
                afu_pkg::MODE_SIGMOID: r = sigmoid_fx(x);
                afu_pkg::MODE_TANH:    r = tanh_fx(x);
                afu_pkg::MODE_RELU:    r = x > 0 ? x : 0;
                default:               r = x;
            endcase
        end
        else if (c == afu_pkg::CMD_DX)
        begin
            case (m)
                afu_pkg::MODE_SIGMOID: r = slope_of_output(m, sigmoid_fx(x));
                afu_pkg::MODE_TANH:    r = slope_of_output(m, tanh_fx(x));
                afu_pkg::MODE_RELU:    r = x > 0 ? 2048 : 0;
                default:               r = 2048;
            endcase
        end
        else if (c == afu_pkg::CMD_DY)
            r = slope_of_output(m, x);
        r = clamp16(r);
        return r[15:0];
    endfunction

    // input monitor: predict on every accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && in_bus.valid && in_bus.ready)
        begin
            if (next_typed)
                result_q.push_back(next_result);
            else
                result_q.push_back(activation(mode_shadow, in_bus.cmd, in_bus.value));
        end
    end

    // output checker
    always @(posedge clk)
    begin
        logic signed [15:0] want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (result_q.size() == 0)
            begin
                $error("result: unexpected transaction, actual %0d", out_bus.result);
                error_count++;
            end
            else
            begin
                want = result_q.pop_front();
                if (out_bus.result !== want)
                begin
                    $error("result: expected %0d, actual %0d", want, out_bus.result);
                    error_count++;
                end
            end
        end
    end

    // receiver: rotating stall patterns plus a long hold-off on request
    initial
    begin
        int pattern;
        int span;
        out_bus.ready = 1'b0;
        pattern = 0;
        span = 0;
        hold_cycles = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cycles = 400;
            end
            if (span == 0)
            begin
                pattern = $urandom_range(0, 3);
                span = $urandom_range(20, 300);
            end
            span--;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_bus.ready = 1'b0;
            end
            else
            begin
                case (pattern)
                    0: out_bus.ready = 1'b1;
                    1: out_bus.ready = ($urandom_range(0, 3) != 0);
                    2: out_bus.ready = ($urandom_range(0, 3) == 0);
                    default: out_bus.ready = ~out_bus.ready;
                endcase
            end
        end
    end

    task automatic send_item(input logic [1:0] c, input logic signed [15:0] v,
                             input bit typed, input logic signed [15:0] res);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        repeat (gap)
        begin
            @(negedge clk);
            in_bus.valid = 1'b0;
        end
        @(negedge clk);
        in_bus.valid = 1'b1;
        in_bus.cmd   = c;
        in_bus.value = v;
        next_typed   = typed;
        next_result  = res;
        do
            @(posedge clk);
        while (!in_bus.ready);
    endtask

    task automatic write_mode(input logic [1:0] m);
        @(negedge clk);
        in_bus.valid = 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.mode  = m;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        mode_shadow = m;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    function automatic logic signed [15:0] random_value();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($signed($urandom_range(0, 8191)) - 4096);
            2:       return 16'($signed($urandom_range(0, 65535)) >>> 3);
            3:       return 16'($signed($urandom_range(0, 255)) - 128);
            4:       return $urandom_range(0, 1) ? 16'(16'h7fff - 16'($urandom_range(0, 3)))
                                                 : 16'(16'h8000 + 16'($urandom_range(0, 3)));
            default: return 16'($signed($urandom_range(0, 16383)) - 8192);
        endcase
    endfunction

    vector_t directed[] = '{
        '{afu_pkg::MODE_SIGMOID, afu_pkg::CMD_APPLY, 16'sd0,      1'b1, 16'sd1024},
        '{afu_pkg::MODE_SIGMOID, afu_pkg::CMD_DY,    16'sd1024,   1'b1, 16'sd512},
        '{afu_pkg::MODE_SIGMOID, afu_pkg::CMD_APPLY, 16'sh7fff,   1'b0, 16'sd0},
        '{afu_pkg::MODE_SIGMOID, afu_pkg::CMD_APPLY, -16'sd32768, 1'b0, 16'sd0},
        '{afu_pkg::MODE_SIGMOID, afu_pkg::CMD_DX,    16'sd0,      1'b0, 16'sd0},
        '{afu_pkg::MODE_SIGMOID, afu_pkg::CMD_DY,    -16'sd32768, 1'b1, -16'sd32768},
        '{afu_pkg::MODE_SIGMOID, afu_pkg::CMD_DY,    16'sh7fff,   1'b1, -16'sd32768},
        '{afu_pkg::MODE_SIGMOID, 2'd3,               16'sd1234,   1'b1, 16'sd0},
        '{afu_pkg::MODE_TANH,    afu_pkg::CMD_APPLY, 16'sd0,      1'b1, 16'sd0},
        '{afu_pkg::MODE_TANH,    afu_pkg::CMD_APPLY, 16'sh7fff,   1'b0, 16'sd0},
        '{afu_pkg::MODE_TANH,    afu_pkg::CMD_APPLY, -16'sd32768, 1'b0, 16'sd0},
        '{afu_pkg::MODE_TANH,    afu_pkg::CMD_DX,    16'sd3000,   1'b0, 16'sd0},
        '{afu_pkg::MODE_TANH,    afu_pkg::CMD_DY,    16'sd2048,   1'b1, 16'sd0},
        '{afu_pkg::MODE_TANH,    afu_pkg::CMD_DY,    16'sd0,      1'b1, 16'sd2048},
        '{afu_pkg::MODE_TANH,    afu_pkg::CMD_DY,    16'sh7fff,   1'b1, -16'sd32768},
        '{afu_pkg::MODE_RELU,    afu_pkg::CMD_APPLY, -16'sd32768, 1'b1, 16'sd0},
        '{afu_pkg::MODE_RELU,    afu_pkg::CMD_APPLY, 16'sd0,      1'b1, 16'sd0},
        '{afu_pkg::MODE_RELU,    afu_pkg::CMD_APPLY, 16'sh7fff,   1'b1, 16'sh7fff},
        '{afu_pkg::MODE_RELU,    afu_pkg::CMD_DX,    16'sd1,      1'b1, 16'sd2048},
        '{afu_pkg::MODE_RELU,    afu_pkg::CMD_DX,    16'sd0,      1'b1, 16'sd0},
        '{afu_pkg::MODE_RELU,    afu_pkg::CMD_DY,    -16'sd5,     1'b1, 16'sd0},
        '{afu_pkg::MODE_LINEAR,  afu_pkg::CMD_APPLY, -16'sd32768, 1'b1, -16'sd32768},
        '{afu_pkg::MODE_LINEAR,  afu_pkg::CMD_APPLY, 16'sh7fff,   1'b1, 16'sh7fff},
        '{afu_pkg::MODE_LINEAR,  afu_pkg::CMD_DX,    -16'sd7,     1'b1, 16'sd2048},
        '{afu_pkg::MODE_LINEAR,  afu_pkg::CMD_DY,    16'sd99,     1'b1, 16'sd2048}
    };

    initial
    begin
        int           i;
        int           p;
        int           n;
        logic [1:0]   phase_mode;
        logic [1:0]   c;
        fill_exp_lut();
        error_count   = 0;
        burst_left    = 0;
        hold_req      = 1'b0;
        mode_shadow   = afu_pkg::MODE_SIGMOID;
        next_typed    = 1'b0;
        next_result   = '0;
        in_bus.valid  = 1'b0;
        in_bus.cmd    = afu_pkg::CMD_APPLY;
        in_bus.value  = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.mode  = afu_pkg::MODE_SIGMOID;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first rows run on the reset mode
        foreach (directed[i])
        begin
            if (directed[i].mode != mode_shadow)
                write_mode(directed[i].mode);
            send_item(directed[i].cmd, directed[i].value, directed[i].typed,
                      directed[i].result);
        end

        for (p = 0; p < 8; p++)
        begin
            phase_mode = (p < 4) ? 2'(3 - p) : 2'($urandom_range(0, 3));
            write_mode(phase_mode);
            n = $urandom_range(200, 280);
            for (i = 0; i < n; i++)
            begin
                if (p == 2 && i == 10)
                    hold_req = 1'b1;
                c = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                send_item(c, random_value(), 1'b0, 16'sd0);
            end
        end
        @(negedge clk);
        in_bus.valid = 1'b0;

        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
